// File: hdl/idpr_pkg.sv
// Package for the int8 dot-product requantize unit.
// Holds the sequencer state type, register index codes and field widths.
// No dependencies.
`timescale 1ns / 1ps

package idpr_pkg;

	localparam int CfgIndexWidth = 3;
	localparam int CfgDataWidth  = 32;

	typedef logic [CfgIndexWidth-1:0] cfg_index_t;

	localparam cfg_index_t REG_LHS_ZERO   = 3'd0;
	localparam cfg_index_t REG_RHS_ZERO   = 3'd1;
	localparam cfg_index_t REG_OUT_ZERO   = 3'd2;
	localparam cfg_index_t REG_MULTIPLIER = 3'd3;
	localparam cfg_index_t REG_SHIFT      = 3'd4;
	localparam cfg_index_t REG_CLAMP_LOW  = 3'd5;
	localparam cfg_index_t REG_CLAMP_HIGH = 3'd6;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ACC,
		ST_REQ_MUL,
		ST_HIGH,
		ST_ROUND,
		ST_EMIT
	} state_t;

endpackage

// File: hdl/idpr_if.sv
// Valid/ready channel interfaces for the int8 dot-product requantize unit.
// idpr_in_if carries operand pairs, idpr_out_if carries int8 results.
// No dependencies.
`timescale 1ns / 1ps

interface idpr_in_if;
	logic              valid;
	logic              ready;
	logic signed [7:0]  vector_value;
	logic signed [7:0]  weight_value;
	logic signed [31:0] bias_value;
	logic              first_term;
	logic              last_term;

	modport source (output valid, vector_value, weight_value, bias_value, first_term,
		last_term, input ready);
	modport sink (input valid, vector_value, weight_value, bias_value, first_term,
		last_term, output ready);
endinterface

interface idpr_out_if;
	logic             valid;
	logic             ready;
	logic signed [7:0] out_value;

	modport source (output valid, out_value, input ready);
	modport sink (input valid, out_value, output ready);
endinterface

// File: hdl/int8_dot_product_requantize_unit.sv
// Top level of the int8 dot-product requantize unit; depends on idpr_pkg and idpr_if.sv.
// A term that is not the last of a row passes accept, multiply and accumulate; the last
// term of a row goes on through requantization multiply, high half, round and emit to the
// result register. A new term is accepted only in idle, once the last one is through, and
// emit waits while a result is held; one shared 32x32 multiplier serves both products.
// Reset (arst_n, asynchronous): accumulator cleared, registers at their defaults.
`timescale 1ns / 1ps

module int8_dot_product_requantize_unit
	import idpr_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  cfg_index_t               wr_index,
	input  logic [CfgDataWidth-1:0]  wr_data,
	idpr_in_if.sink                  in_item,
	idpr_out_if.source               out_item
);

	// configuration registers
	logic signed [8:0]  lhs_zero_q;
	logic signed [8:0]  rhs_zero_q;
	logic signed [7:0]  out_zero_q;
	logic signed [31:0] multiplier_q;
	logic signed [5:0]  shift_q;
	logic signed [7:0]  clamp_low_q;
	logic signed [7:0]  clamp_high_q;

	state_t state_q, state_d;

	logic signed [9:0]  vec_q, wgt_q;
	logic [31:0]        bias_q;
	logic               first_q, last_q;
	logic [31:0]        acc_q;
	logic signed [63:0] prod_q;
	logic [31:0]        high_q;
	logic signed [31:0] rnd_q;
	logic               out_valid_q;
	logic signed [7:0]  out_value_q;

	logic               in_take;
	logic               out_free;
	logic signed [9:0]  vec_off, wgt_off;
	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] mul_p;
	logic [31:0]        acc_shl;
	logic [5:0]         shift_neg;
	logic [4:0]         rs;
	logic [63:0]        high_sum;
	logic [31:0]        rmask, rrem, rthr;
	logic signed [31:0] rsh, rnd;
	logic signed [32:0] osum, clip_lo, clip;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lhs_zero_q   <= '0;
			rhs_zero_q   <= '0;
			out_zero_q   <= '0;
			multiplier_q <= 32'sh4000_0000;
			shift_q      <= '0;
			clamp_low_q  <= -8'sd128;
			clamp_high_q <= 8'sd127;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_LHS_ZERO:   lhs_zero_q   <= wr_data[8:0];
				REG_RHS_ZERO:   rhs_zero_q   <= wr_data[8:0];
				REG_OUT_ZERO:   out_zero_q   <= wr_data[7:0];
				REG_MULTIPLIER: multiplier_q <= wr_data[31:0];
				REG_SHIFT:      shift_q      <= wr_data[5:0];
				REG_CLAMP_LOW:  clamp_low_q  <= wr_data[7:0];
				REG_CLAMP_HIGH: clamp_high_q <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	assign in_item.ready = (state_q == ST_IDLE);
	assign in_take       = in_item.valid && in_item.ready;
	assign out_free      = !out_valid_q || out_item.ready;

	assign vec_off = 10'(in_item.vector_value) + 10'(lhs_zero_q);
	assign wgt_off = 10'(in_item.weight_value) + 10'(rhs_zero_q);

	// positive shift moves the accumulator left before the multiply
	assign acc_shl = shift_q[5] ? acc_q : (acc_q << shift_q[4:0]);

	// shared multiplier: operand product, then requantization product
	always_comb begin
		if (state_q == ST_REQ_MUL) begin
			mul_a = $signed(acc_shl);
			mul_b = multiplier_q;
		end else begin
			mul_a = 32'(vec_q);
			mul_b = 32'(wgt_q);
		end
	end
	assign mul_p = 64'(mul_a) * 64'(mul_b);

	// rounding doubling high half: add 2^30, keep bits 62..31
	assign high_sum = prod_q + 64'h0000_0000_4000_0000;

	// negative shift rounds right; a shift of -32 saturates at 31
	assign shift_neg = 6'd0 - shift_q;
	assign rs = shift_q[5] ? (shift_neg[5] ? 5'd31 : shift_neg[4:0]) : 5'd0;

	assign rmask = (32'd1 << rs) - 32'd1;
	assign rrem  = high_q & rmask;
	assign rsh   = $signed(high_q) >>> rs;
	assign rthr  = (rmask >> 1) + {31'd0, high_q[31]};
	assign rnd   = rsh + ((rrem > rthr) ? 32'sd1 : 32'sd0);

	// output offset, then clamp low before high so crossed bounds give the high bound
	assign osum    = 33'(rnd_q) + 33'(out_zero_q);
	assign clip_lo = (osum < 33'(clamp_low_q)) ? 33'(clamp_low_q) : osum;
	assign clip    = (clip_lo > 33'(clamp_high_q)) ? 33'(clamp_high_q) : clip_lo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:    if (in_take) state_d = ST_MUL;
			ST_MUL:     state_d = ST_ACC;
			ST_ACC:     state_d = last_q ? ST_REQ_MUL : ST_IDLE;
			ST_REQ_MUL: state_d = ST_HIGH;
			ST_HIGH:    state_d = ST_ROUND;
			ST_ROUND:   state_d = ST_EMIT;
			ST_EMIT:    if (out_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// operand and pipeline payload
	always_ff @(posedge clk) begin
		if (in_take) begin
			vec_q   <= vec_off;
			wgt_q   <= wgt_off;
			bias_q  <= in_item.bias_value;
			first_q <= in_item.first_term;
			last_q  <= in_item.last_term;
		end
		if (state_q == ST_MUL || state_q == ST_REQ_MUL) begin
			prod_q <= mul_p;
		end
		if (state_q == ST_HIGH) begin
			high_q <= high_sum[62:31];
		end
		if (state_q == ST_ROUND) begin
			rnd_q <= rnd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (state_q == ST_ACC) begin
			acc_q <= (first_q ? bias_q : acc_q) + prod_q[31:0];
		end
	end

	// result register: hold until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_item.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			out_value_q <= clip[7:0];
		end
	end

	assign out_item.valid     = out_valid_q;
	assign out_item.out_value = out_value_q;

endmodule
